// ===== rtl/trie_word_store_assert.svh =====
// Assertion macros shared by the trie word store.
`ifndef TRIE_WORD_STORE_ASSERT_SVH
`define TRIE_WORD_STORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TWS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tws_pkg.sv =====
package tws_pkg;

	// Fixed field widths
	localparam int OPC_W = 2;
	localparam int LTR_W = 5;
	// Wide enough to compare a letter against any alphabet size up to 256
	localparam int LTR_CMP_W = 9;

	// Word opcodes
	localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPC_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OPC_W-1:0] OP_PREFIX = 2'd2;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_TERM,
		ST_RESP
	} tws_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic update;
		logic term;
		logic resp;
	} tws_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic need_read;
		logic item_last;
		logic last_q;
		logic out_free;
	} tws_sts_t;

endpackage

// ===== rtl/tws_ctrl.sv =====
module tws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tws_pkg::tws_sts_t sts,
	output tws_pkg::tws_cmd_t cmd
);

	tws_pkg::tws_state_t state_q;
	tws_pkg::tws_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tws_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tws_pkg::ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = tws_pkg::ST_IDLE;
				end
			end
			tws_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.need_read) begin
						state_d = tws_pkg::ST_UPDATE;
					end else if (sts.item_last) begin
						state_d = tws_pkg::ST_TERM;
					end
				end
			end
			tws_pkg::ST_UPDATE: begin
				state_d = sts.last_q ? tws_pkg::ST_TERM : tws_pkg::ST_IDLE;
			end
			tws_pkg::ST_TERM: begin
				state_d = tws_pkg::ST_RESP;
			end
			tws_pkg::ST_RESP: begin
				if (sts.out_free) begin
					state_d = tws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tws_pkg::ST_CLEAR;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tws_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			tws_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			tws_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			tws_pkg::ST_TERM: begin
				cmd.term = 1'b1;
			end
			tws_pkg::ST_RESP: begin
				cmd.resp = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/tws_dp.sv =====
module tws_dp #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tws_pkg::tws_cmd_t         cmd,
	output tws_pkg::tws_sts_t         sts,
	input  logic [tws_pkg::OPC_W-1:0] opcode,
	input  logic [tws_pkg::LTR_W-1:0] letter,
	input  logic                      has_letter,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic                      full_res
);

	localparam int DEPTH  = NODES * ALPHABET;
	localparam int PTR_W  = $clog2(NODES);
	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	// Node tables
	logic [PTR_W-1:0] child_mem [DEPTH];
	logic             term_mem  [NODES];

	logic [ADDR_W-1:0]         clr_cnt_q;
	logic [CNT_W-1:0]          node_count_q;
	logic [PTR_W-1:0]          node_q;
	logic                      miss_q;
	logic                      full_q;
	logic [tws_pkg::OPC_W-1:0] op_q;
	logic                      mid_word_q;
	logic                      last_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [PTR_W-1:0]          child_rd_q;
	logic                      term_rd_q;
	logic                      out_valid_q;
	logic                      found_q;
	logic                      full_res_q;

	logic [tws_pkg::OPC_W-1:0] op_eff;
	logic [PTR_W-1:0]          node_eff;
	logic                      miss_eff;
	logic                      full_eff;
	logic                      walk;
	logic                      bad_letter;
	logic [ADDR_W-1:0]         addr_c;
	logic                      child_zero;
	logic                      alloc;
	logic                      table_full;
	logic                      set_term;
	logic                      clr_term;

	// Word state as seen by the incoming beat: a new word starts at the root
	assign op_eff   = mid_word_q ? op_q : opcode;
	assign node_eff = mid_word_q ? node_q : '0;
	assign miss_eff = mid_word_q & miss_q;
	assign full_eff = mid_word_q & full_q;

	assign walk = has_letter && !miss_eff && !full_eff &&
		(op_eff == tws_pkg::OP_INSERT || op_eff == tws_pkg::OP_SEARCH ||
		 op_eff == tws_pkg::OP_PREFIX);
	assign bad_letter = tws_pkg::LTR_CMP_W'(letter) >= tws_pkg::LTR_CMP_W'(ALPHABET);

	// Child slot address: node row plus letter column
	assign addr_c = ADDR_W'(node_eff) * ADDR_W'(ALPHABET) + ADDR_W'(letter);

	// Child lookup outcome
	assign child_zero = (child_rd_q == '0);
	assign table_full = (node_count_q == CNT_W'(NODES));
	assign alloc      = cmd.update && child_zero && (op_q == tws_pkg::OP_INSERT) &&
		!table_full;

	assign set_term = cmd.term && (op_q == tws_pkg::OP_INSERT) && !miss_q && !full_q;
	assign clr_term = cmd.clear && ({1'b0, clr_cnt_q} < (ADDR_W + 1)'(NODES));

	// Status
	assign sts.clear_done = (clr_cnt_q == ADDR_W'(DEPTH - 1));
	assign sts.need_read  = walk && !bad_letter;
	assign sts.item_last  = last;
	assign sts.last_q     = last_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	// Sweep the tables after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear && !sts.clear_done) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	// Child table: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			child_mem[clr_cnt_q] <= '0;
		end else if (alloc) begin
			child_mem[addr_q] <= node_count_q[PTR_W-1:0];
		end
		if (cmd.accept && sts.need_read) begin
			child_rd_q <= child_mem[addr_c];
		end
	end

	// Terminal marks: one write, one registered read
	always_ff @(posedge clk) begin
		if (clr_term) begin
			term_mem[clr_cnt_q[PTR_W-1:0]] <= 1'b0;
		end else if (set_term) begin
			term_mem[node_q] <= 1'b1;
		end
		if (cmd.term) begin
			term_rd_q <= term_mem[node_q];
		end
	end

	// Hold the slot address for the update beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= addr_c;
		end
	end

	// Word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			node_q       <= '0;
			miss_q       <= 1'b0;
			full_q       <= 1'b0;
			op_q         <= tws_pkg::OP_INSERT;
			mid_word_q   <= 1'b0;
			last_q       <= 1'b0;
		end else if (cmd.accept) begin
			op_q       <= op_eff;
			node_q     <= node_eff;
			miss_q     <= miss_eff | (walk & bad_letter);
			full_q     <= full_eff;
			mid_word_q <= !last;
			last_q     <= last;
		end else if (cmd.update) begin
			if (!child_zero) begin
				node_q <= child_rd_q;
			end else if (op_q != tws_pkg::OP_INSERT) begin
				miss_q <= 1'b1;
			end else if (table_full) begin
				full_q <= 1'b1;
			end else begin
				node_q       <= node_count_q[PTR_W-1:0];
				node_count_q <= node_count_q + CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			case (op_q)
				tws_pkg::OP_INSERT: begin
					found_q    <= 1'b0;
					full_res_q <= full_q;
				end
				tws_pkg::OP_SEARCH: begin
					found_q    <= !miss_q && term_rd_q;
					full_res_q <= 1'b0;
				end
				tws_pkg::OP_PREFIX: begin
					found_q    <= !miss_q;
					full_res_q <= 1'b0;
				end
				default: begin
					found_q    <= 1'b0;
					full_res_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign full_res  = full_res_q;

endmodule

// ===== rtl/trie_word_store.sv =====
// Prefix tree store for lower-case words, fed one letter per beat. After reset the
// block sweeps its child table and terminal marks with in_ready low. Then, for a
// beat that walks the tree, the child slot is read from the child table at the
// accept edge and the pointer is followed or a node allocated in the next cycle;
// the table's single read port and the dependence of each address on the previous
// child mean that no beat is taken until the previous walking beat has updated.
// A beat that does not walk (no letter, or the word already failed) skips the update
// state. The last beat of a word then passes the terminal state for the mark access
// and the response state for the result load, plus any wait for the output register
// to empty; a new word may be accepted while a result waits to be taken.
`include "trie_word_store_assert.svh"

module trie_word_store #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tws_pkg::OPC_W-1:0] opcode,
	input  logic [tws_pkg::LTR_W-1:0] letter,
	input  logic                      has_letter,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic                      full_res
);

	tws_pkg::tws_cmd_t cmd;
	tws_pkg::tws_sts_t sts;

	// Sequencer
	tws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Tables and word state
	tws_dp #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.letter     (letter),
		.has_letter (has_letter),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.full_res   (full_res)
	);

	`TWS_ASSERT_SAME(a_no_accept_in_clear, cmd.clear, !in_ready, "beat offered during sweep")
	`TWS_ASSERT_NEXT(a_read_then_update, in_valid && in_ready && sts.need_read, cmd.update, "child read not followed by update")
	`TWS_ASSERT_SAME(a_resp_slot_free, cmd.resp, !out_valid || out_ready, "result overwrites a waiting one")
	`TWS_ASSERT_SAME(a_found_excl_full, out_valid, !(found && full_res), "found and full together")

endmodule
